>>> hdl/smab_pkg.sv
// smab_pkg: shared types and constants of the sized-access byte memory
// item structs, opcode and size codes, default sizes
// depends on nothing; imported by sized_access_byte_memory_core and the testbench
package smab_pkg;

  // store depth in bytes by default, and number of byte lanes (banks)
  localparam int unsigned MEM_BYTES_DEF = 1024;
  localparam int unsigned LANES         = 4;

  // configuration register
  localparam int unsigned CFG_W        = 11;
  localparam logic [10:0] ACTIVE_RESET = 11'd1024;

  // width of address and limit comparisons (16-bit address plus a word)
  localparam int unsigned CMP_W = 18;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } smab_op_t;

  typedef enum logic [1:0] {
    SIZE_BYTE    = 2'd0,
    SIZE_HALF    = 2'd1,
    SIZE_WORD    = 2'd2,
    SIZE_UNKNOWN = 2'd3
  } smab_size_t;

  typedef struct packed {
    smab_op_t           opcode;
    smab_size_t         size_code;
    logic signed [15:0] address;
    logic [31:0]        write_data;
  } smab_in_t;

  typedef struct packed {
    logic        violation;
    logic [31:0] read_data;
  } smab_out_t;

endpackage

>>> hdl/sized_access_byte_memory_core.sv
// sized_access_byte_memory_core: top level of the sized-access byte memory
// four byte banks, range check, little-endian lane steering, clearing pass
// depends on smab_pkg and smab_bank
//
//   channel | ports                         | handshake
//   --------+-------------------------------+------------------------------
//   input   | start, busy, in_item          | taken when start && !busy
//   result  | out_valid, out_item           | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_data| written when valid && ready
//
// one item per cycle when not busy: the access goes to all four banks in the
// cycle it is taken, and its result (reads, and writes that hit a violation)
// is strobed in the next cycle, once the registered bank read data is there.
// after reset a clearing pass zeroes one row of all banks per cycle, through
// all (MEM_BYTES+3)/4 rows (256 by default); busy is high meanwhile.
// cfg_ready is always high; the result side cannot stall the block.
module sized_access_byte_memory_core #(
  parameter int unsigned MEM_BYTES = smab_pkg::MEM_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  smab_pkg::smab_in_t       in_item,
  output logic                     out_valid,
  output smab_pkg::smab_out_t      out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [smab_pkg::CFG_W-1:0] cfg_data
);

  import smab_pkg::*;

  localparam int unsigned ROWS  = (MEM_BYTES + LANES - 1) / LANES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [CMP_W-1:0] MEM_LIMIT = CMP_W'(MEM_BYTES);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  // configuration and clearing state
  logic [CFG_W-1:0] active_bytes_r;
  logic             clr_busy_r;
  logic [ROW_W-1:0] clr_row_r;

  // second-stage state
  logic             pend_r;
  logic             viol_r;
  logic [1:0]       off_r;
  smab_size_t       size_r;

  logic             accept;
  logic [CMP_W-1:0] addr_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] limit;
  logic             bad_size;
  logic             neg_addr;
  logic             viol;

  logic             bank_we   [LANES];
  logic [ROW_W-1:0] bank_row  [LANES];
  logic [7:0]       bank_wdat [LANES];
  logic [7:0]       bank_rdat [LANES];

  assign cfg_ready = 1'b1;
  assign busy      = clr_busy_r;
  assign accept    = start && !clr_busy_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bytes_r <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_bytes_r <= cfg_data;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_row_r == LAST_ROW) begin
        clr_busy_r <= 1'b0;
      end
      clr_row_r <= clr_row_r + 1'b1;
    end
  end

  // range check of the whole access
  always_comb begin
    addr_ext = {2'b00, $unsigned(in_item.address)};
    limit    = (CMP_W'(active_bytes_r) > MEM_LIMIT) ? MEM_LIMIT : CMP_W'(active_bytes_r);
    bad_size = (in_item.size_code == SIZE_UNKNOWN);
    neg_addr = in_item.address[15];
    case (in_item.size_code)
      SIZE_BYTE: count_ext = CMP_W'(1);
      SIZE_HALF: count_ext = CMP_W'(2);
      SIZE_WORD: count_ext = CMP_W'(4);
      default:   count_ext = CMP_W'(0);
    endcase
    viol = bad_size || neg_addr || ((addr_ext + count_ext) > limit);
  end

  // lane steering: bank b holds byte k where (address + k) mod 4 == b
  always_comb begin
    logic [1:0]       k;
    logic [CMP_W-1:0] byte_addr;
    logic             in_range;
    for (int b = 0; b < LANES; b++) begin
      k         = 2'(2'(b) - in_item.address[1:0]);
      byte_addr = addr_ext + CMP_W'(k);
      in_range  = (CMP_W'(k) < count_ext) && (byte_addr < limit);
      if (clr_busy_r) begin
        bank_we[b]   = 1'b1;
        bank_row[b]  = clr_row_r;
        bank_wdat[b] = 8'h00;
      end else begin
        bank_we[b]   = accept && (in_item.opcode == OP_WRITE) && !bad_size
                       && !neg_addr && in_range;
        bank_row[b]  = byte_addr[ROW_W+1:2];
        bank_wdat[b] = in_item.write_data[8*k +: 8];
      end
    end
  end

  // byte banks
  for (genvar g = 0; g < LANES; g++) begin : g_bank
    smab_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk     (clk),
      .wr_en   (bank_we[g]),
      .row     (bank_row[g]),
      .wr_data (bank_wdat[g]),
      .rd_data (bank_rdat[g])
    );
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept && ((in_item.opcode == OP_READ) || viol);
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    viol_r <= viol;
    off_r  <= in_item.address[1:0];
    size_r <= in_item.size_code;
  end

  // little-endian assembly of the read value
  always_comb begin
    logic [1:0] lane;
    logic [2:0] nbytes;
    case (size_r)
      SIZE_BYTE: nbytes = 3'd1;
      SIZE_HALF: nbytes = 3'd2;
      SIZE_WORD: nbytes = 3'd4;
      default:   nbytes = 3'd0;
    endcase
    out_item.violation = viol_r;
    out_item.read_data = '0;
    for (int k = 0; k < LANES; k++) begin
      lane = 2'(off_r + 2'(k));
      if (!viol_r && (3'(k) < nbytes)) begin
        out_item.read_data[8*k +: 8] = bank_rdat[lane];
      end
    end
  end

  assign out_valid = pend_r;

endmodule

>>> hdl/smab_bank.sv
// smab_bank: one byte lane of the store, a single-port synchronous ram
// one row per cycle is read, and written when enabled; read data registered
// depends on nothing
module smab_bank #(
  parameter int unsigned ROWS  = 256,
  parameter int unsigned ROW_W = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] row,
  input  logic [7:0]       wr_data,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [ROWS];
  logic [7:0] rd_data_r;

  // single port: write when enabled; the row is read always, giving its old data on a write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row] <= wr_data;
    end
    rd_data_r <= mem[row];
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/smab_access_checker.sv
// smab_access_checker: watches the item, result and config channels of the byte memory
// keeps a shadow copy of the store, works out the expected results and compares them
// depends on smab_pkg
module smab_access_checker #(
  parameter int unsigned MEM_BYTES = smab_pkg::MEM_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  smab_pkg::smab_in_t         in_item,
  input  logic                       out_valid,
  input  smab_pkg::smab_out_t        out_item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [smab_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import smab_pkg::*;

  // shadow of the store and of the active size
  logic [7:0]       shadow_bytes [MEM_BYTES];
  logic [CFG_W-1:0] active_bytes;
  smab_out_t        replies_due [$];

  // carry out one access on the shadow store, giving its result if it has one
  task automatic apply_access(input smab_in_t acc, output bit has_reply,
                              output smab_out_t reply);
    int unsigned limit;
    int unsigned base;
    int unsigned count;
    int unsigned a;
    has_reply = 1'b0;
    reply     = '0;
    limit = (active_bytes > MEM_BYTES) ? MEM_BYTES : active_bytes;
    base  = {16'd0, acc.address};
    count = 1 << acc.size_code;
    if (acc.size_code == SIZE_UNKNOWN || acc.address[15]) begin
      // unknown size or negative address: nothing stored, nothing read
      has_reply       = 1'b1;
      reply.violation = 1'b1;
    end else if (acc.opcode == OP_WRITE) begin
      // bytes go in ascending order until one falls outside the active size
      for (int k = 0; k < count; k++) begin
        a = base + k;
        if (a >= limit) begin
          has_reply       = 1'b1;
          reply.violation = 1'b1;
          break;
        end
        shadow_bytes[a] = acc.write_data[8*k +: 8];
      end
    end else begin
      has_reply = 1'b1;
      if (base + count > limit) begin
        reply.violation = 1'b1;
      end else begin
        for (int k = 0; k < count; k++)
          reply.read_data[8*k +: 8] = shadow_bytes[base + k];
      end
    end
  endtask

  // results are checked before the item of the same edge is applied
  always @(posedge clk) begin
    smab_out_t want;
    bit        has;
    if (!rst_n) begin
      foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
      active_bytes = ACTIVE_RESET;
      replies_due.delete();
      fail_count = 0;
    end else begin
      // compare each result with the oldest one due
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result: violation=%0b read_data=%h",
                     $realtime, out_item.violation, out_item.read_data);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (want.violation !== out_item.violation ||
              want.read_data !== out_item.read_data) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected viol=%0b data=%h, got viol=%0b data=%h",
                       $realtime, want.violation, want.read_data,
                       out_item.violation, out_item.read_data);
            fail_count++;
          end
        end
      end
      // active size register
      if (cfg_valid && cfg_ready) active_bytes = cfg_data;
      // accepted item
      if (start && !busy) begin
        apply_access(in_item, has, want);
        if (has) replies_due = {replies_due, want};
      end
    end
    outstanding <= replies_due.size();
  end

endmodule

>>> tb/testbench.sv
// testbench: drives items and active-size writes into sized_access_byte_memory_core
// the checker beside it predicts and compares; this module gives the verdict
// depends on smab_pkg, sized_access_byte_memory_core and smab_access_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smab_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASES     = 10;
  localparam int unsigned PER_PHASE  = 90;
  // active sizes per phase; the eighth is drawn at random
  localparam int unsigned ACTIVE_STEPS [PHASES] =
    '{1024, 0, 2047, 1, 3, 517, 1023, 0, 4, 1024};

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  smab_in_t         in_item   = '0;
  logic             out_valid;
  smab_out_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;
  int               fail_count;
  int               outstanding;
  int               quiet_cycles = 0;
  int               burst_left   = 0;

  sized_access_byte_memory_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  smab_access_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // present one item after a random gap and wait until it is taken
  task automatic send_access(input smab_in_t acc);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= acc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // write the active size once the block has drained
  task automatic set_active(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic smab_in_t fixed_access(smab_op_t op, smab_size_t sz,
                                            logic [15:0] addr, logic [31:0] data);
    smab_in_t acc;
    acc.opcode     = op;
    acc.size_code  = sz;
    acc.address    = addr;
    acc.write_data = data;
    return acc;
  endfunction

  // random access, often in a small window so reads see earlier writes
  function automatic smab_in_t random_access(int unsigned limit);
    smab_in_t    acc;
    int unsigned pick;
    acc.opcode = smab_op_t'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 3)      acc.size_code = SIZE_BYTE;
    else if (pick < 6) acc.size_code = SIZE_HALF;
    else if (pick < 9) acc.size_code = SIZE_WORD;
    else               acc.size_code = SIZE_UNKNOWN;
    acc.write_data = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: acc.address = 16'($urandom_range(0, 31));
      4, 5:       acc.address = 16'((limit > 5 ? limit - 5 : 0) + $urandom_range(0, 8));
      6, 7:       acc.address = 16'($urandom_range(0, 1023));
      8:          acc.address = 16'($urandom_range(32768, 65535));
      default:    acc.address = 16'($urandom_range(0, 65535));
    endcase
    return acc;
  endfunction

  initial begin
    int unsigned active;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // clearing pass after reset
    while (busy) @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      active = (ph == 7) ? $urandom_range(0, 2047) : ACTIVE_STEPS[ph];
      set_active(active[CFG_W-1:0]);
      if (ph == 0) begin
        // little-endian word, byte and halfword reads
        send_access(fixed_access(OP_WRITE, SIZE_WORD, 16'd0, 32'hDEADBEEF));
        send_access(fixed_access(OP_READ,  SIZE_WORD, 16'd0, 32'h0));
        send_access(fixed_access(OP_READ,  SIZE_BYTE, 16'd1, 32'hFFFFFFFF));
        send_access(fixed_access(OP_READ,  SIZE_HALF, 16'd2, 32'h0));
        // byte write keeps only the low byte, halfword write its low two
        send_access(fixed_access(OP_WRITE, SIZE_BYTE, 16'd4, 32'hFFFFFFFF));
        send_access(fixed_access(OP_WRITE, SIZE_HALF, 16'd6, 32'h12345678));
        send_access(fixed_access(OP_READ,  SIZE_WORD, 16'd4, 32'h0));
        // partial write at the top of the active size
        send_access(fixed_access(OP_WRITE, SIZE_WORD, 16'd1022, 32'hA1B2C3D4));
        send_access(fixed_access(OP_READ,  SIZE_HALF, 16'd1022, 32'h0));
        send_access(fixed_access(OP_READ,  SIZE_WORD, 16'd1020, 32'h0));
        send_access(fixed_access(OP_READ,  SIZE_WORD, 16'd1021, 32'h0));
        send_access(fixed_access(OP_READ,  SIZE_BYTE, 16'd1023, 32'h0));
        // unknown size code
        send_access(fixed_access(OP_WRITE, SIZE_UNKNOWN, 16'd8, 32'h55AA55AA));
        send_access(fixed_access(OP_READ,  SIZE_UNKNOWN, 16'd8, 32'h0));
        send_access(fixed_access(OP_READ,  SIZE_WORD, 16'd8, 32'h0));
        // negative addresses
        send_access(fixed_access(OP_WRITE, SIZE_BYTE, 16'h8000, 32'h000000FF));
        send_access(fixed_access(OP_WRITE, SIZE_WORD, 16'hFFFF, 32'hFFFFFFFF));
        send_access(fixed_access(OP_READ,  SIZE_BYTE, 16'hFFFF, 32'h0));
        // largest positive address
        send_access(fixed_access(OP_WRITE, SIZE_WORD, 16'h7FFF, 32'h01020304));
        send_access(fixed_access(OP_READ,  SIZE_BYTE, 16'h7FFF, 32'h0));
        send_access(fixed_access(OP_READ,  SIZE_WORD, 16'd0, 32'h0));
      end
      repeat (PER_PHASE) send_access(random_access(active > 1024 ? 1024 : active));
    end

    // drain and settle
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/smab_pkg.sv
hdl/smab_bank.sv
hdl/sized_access_byte_memory_core.sv
tb/smab_access_checker.sv
tb/testbench.sv
